// ===== hdl/bda_pkg.sv =====
package bda_pkg;

  // Conversion geometry: 32 binary bits into ten packed BCD digits.
  localparam int NUM_BITS   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(NUM_BITS);

  // Counter start values for the two phases.
  localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(NUM_BITS - 1);
  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

  // ASCII code of the character zero, truncated to the character width.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
    logic last;
  } ctrl_t;

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// Characters leave after the conversion phase, one character per cycle once shown;
// the last character ends the transaction.
// A new start is taken only when idle (busy low), after the 32-step bit-serial
// shift-and-add-3 loop and the 10-step digit shift-out of the previous number.
// The receiver cannot stall; each character is shown for exactly one cycle.
// Reset (synchronous, active low) returns the sequencer to idle and clears the strobe.
module binary_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bda_pkg::NUM_BITS-1:0]       in_value,
  output logic                               out_valid,
  output logic [bda_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                               out_is_last
);
  import bda_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  ctrl_t             ctrl;
  logic [DIGIT_W-1:0] top_digit;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONV;
          cnt_nxt   = LAST_BIT;
        end
      end
      ST_CONV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = LAST_DIGIT;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath commands decoded from the state.
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: ctrl.load = start;
      ST_CONV: ctrl.conv = 1'b1;
      ST_EMIT: begin
        ctrl.emit = 1'b1;
        ctrl.last = (cnt_r == '0);
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  bda_dabble u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .in_value  (in_value),
    .top_digit (top_digit)
  );

  bda_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .top_digit      (top_digit),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last)
  );

  // An accepted transaction starts the conversion phase.
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CONV && cnt_r == LAST_BIT))
    else $error("accepted transaction did not start conversion");

  // Characters only follow an emission cycle.
  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("character strobe outside emission");

  // The last flag never stands without a strobe.
  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_last |-> out_valid)
    else $error("last flag without strobe");

  // Conversion always hands over to emission with the full digit count.
  a_conv_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r == '0) |=> (state_r == ST_EMIT && cnt_r == LAST_DIGIT))
    else $error("emission did not start after conversion");

endmodule

// ===== hdl/bda_dabble.sv =====
module bda_dabble (
  input  logic                             clk,
  input  bda_pkg::ctrl_t                   ctrl,
  input  logic [bda_pkg::NUM_BITS-1:0]     in_value,
  output logic [bda_pkg::DIGIT_W-1:0]      top_digit
);
  import bda_pkg::*;

  logic [NUM_BITS-1:0] val_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BCD_W-1:0]    adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // One input bit enters the BCD register per conversion cycle; during
  // emission the digits move out of the top one per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_r <= in_value;
      bcd_r <= '0;
    end else if (ctrl.conv) begin
      val_r <= {val_r[NUM_BITS-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], val_r[NUM_BITS-1]};
    end else if (ctrl.emit) begin
      bcd_r <= {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

// ===== hdl/bda_emit.sv =====
module bda_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bda_pkg::ctrl_t                ctrl,
  input  logic [bda_pkg::DIGIT_W-1:0]   top_digit,
  output logic                          out_valid,
  output logic [bda_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_is_last
);
  import bda_pkg::*;

  logic              seen_r;
  logic              seen_nxt;
  logic              valid_r;
  logic              valid_nxt;
  logic              last_r;
  logic [CHAR_W-1:0] char_r;

  // A digit is shown once a nonzero digit has appeared, and always the last.
  always_comb begin
    seen_nxt  = seen_r;
    valid_nxt = 1'b0;
    if (ctrl.load) begin
      seen_nxt = 1'b0;
    end else if (ctrl.emit) begin
      valid_nxt = seen_r || (top_digit != '0) || ctrl.last;
      seen_nxt  = valid_nxt;
    end
  end

  // Control flags take reset; the character register does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
      last_r  <= valid_nxt && ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      char_r <= ASCII_ZERO + CHAR_W'(top_digit);
    end
  end

  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_is_last    = last_r;

  // The final digit position always yields a closing character.
  a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && ctrl.last) |=> (out_valid && out_is_last))
    else $error("final digit was not emitted as last");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import bda_pkg::*;

  // One number to convert, with the idle time the sender spends before it.
  typedef struct {
    logic [NUM_BITS-1:0] value;
    int                  gap;
    bit                  drain;
  } number_t;

  // One character that the block is expected to print.
  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } digit_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [NUM_BITS-1:0] in_value = '0;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_digit_char;
  logic                out_is_last;

  number_t             numbers_pending[$];
  digit_t              digits_due[$];
  logic                taken = 1'b0;
  int                  idle_cycles = 0;
  int                  errors = 0;

  binary_to_decimal_ascii u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Converts a number with shift-and-add-3 and queues its printed digits.
  function automatic void push_decimal_digits(input logic [NUM_BITS-1:0] v);
    logic [BCD_W-1:0]   bcd;
    logic [DIGIT_W-1:0] nib;
    int                 top;
    digit_t             dg;
    bcd = '0;
    top = 0;
    for (int b = NUM_BITS - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        nib = bcd[d*DIGIT_W +: DIGIT_W];
        if (nib >= 4'd5) begin
          bcd[d*DIGIT_W +: DIGIT_W] = nib + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], v[b]};
    end
    // Leading zero digits are dropped; zero itself still prints one digit.
    for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        top = d;
        break;
      end
    end
    for (int d = top; d >= 0; d--) begin
      dg.char_code = ASCII_ZERO + CHAR_W'(bcd[d*DIGIT_W +: DIGIT_W]);
      dg.last      = (d == 0);
      digits_due.push_back(dg);
    end
  endfunction

  // Driver: presents numbers at the falling edge, honoring each gap.
  always @(negedge clk) begin
    if (rst_n && !(start && !taken)) begin
      if (numbers_pending.size() == 0) begin
        start <= 1'b0;
      end else if (idle_cycles < numbers_pending[0].gap ||
                   (numbers_pending[0].drain && digits_due.size() != 0)) begin
        start    <= 1'b0;
        in_value <= $urandom;
        if (!busy) begin
          idle_cycles <= idle_cycles + 1;
        end
      end else begin
        start       <= 1'b1;
        in_value    <= numbers_pending[0].value;
        idle_cycles <= 0;
        void'(numbers_pending.pop_front());
      end
    end
  end

  // Monitor: checks each printed character and predicts each accepted number.
  always @(posedge clk) begin
    digit_t exp_dg;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (digits_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                   $time, out_digit_char, out_is_last);
        end else begin
          exp_dg = digits_due.pop_front();
          if (out_digit_char !== exp_dg.char_code) begin
            errors++;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, exp_dg.char_code, out_digit_char);
          end
          if (out_is_last !== exp_dg.last) begin
            errors++;
            $display("%0t: is_last mismatch: expected %0b, actual %0b",
                     $time, exp_dg.last, out_is_last);
          end
        end
      end
      if (start && !busy) begin
        push_decimal_digits(in_value);
      end
      taken <= start && !busy;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [NUM_BITS-1:0] pow10[10];
    logic [NUM_BITS-1:0] directed[$];
    number_t             num;
    int                  k;
    pow10[0] = 1;
    for (int i = 1; i < 10; i++) begin
      pow10[i] = pow10[i-1] * 10;
    end
    // Zero, single digits, digit-count boundaries and the all-ones extreme.
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                 32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4000000000,
                 32'd2147483648, 32'd2147483647, 32'h55555555, 32'hAAAAAAAA,
                 32'd1234567890, 32'd123456789, 32'd1000000001, 32'd505050505};
    foreach (directed[i]) begin
      num.value = directed[i];
      num.gap   = (i < 8) ? 0 : $urandom_range(0, 5);
      num.drain = (i == 10);
      numbers_pending.push_back(num);
    end
    for (int i = 0; i < 91; i++) begin
      case ($urandom_range(0, 3))
        0: num.value = $urandom;
        1: num.value = $urandom >> $urandom_range(0, 31);
        2: begin
          k = $urandom_range(0, 9);
          num.value = pow10[k] - $urandom_range(0, 1);
        end
        default: num.value = $urandom % pow10[$urandom_range(1, 9)];
      endcase
      // Bursts with no idle time between stretches of random gaps.
      num.gap   = ((i / 15) % 2 == 1) ? 0 : $urandom_range(0, 5);
      num.drain = (i % 37 == 20);
      numbers_pending.push_back(num);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (numbers_pending.size() == 0 && !start);
    wait (digits_due.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("binary_to_decimal_ascii verification clean");
    end else begin
      $display("binary_to_decimal_ascii verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("binary_to_decimal_ascii verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bda_pkg.sv
hdl/bda_dabble.sv
hdl/bda_emit.sv
hdl/binary_to_decimal_ascii.sv
tb/testbench.sv
